FILE: rtl/phbs_pkg.sv
`timescale 1ns / 1ps

package phbs_pkg;

   // Lights held in the register file, and how many of them are shaded.
   localparam int LIGHT_REGS  = 4;
   localparam int LIGHT_COUNT = 4;
   localparam int LIGHT_USED  = (LIGHT_COUNT < LIGHT_REGS) ? LIGHT_COUNT : LIGHT_REGS;
   localparam int LIGHT_IDX_W = $clog2(LIGHT_REGS);

   // Configuration port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int GAIN_W     = 9;
   localparam int SHINE_W    = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LIGHT_ZERO    = 4'd0,
      REG_LIGHT_ONE     = 4'd1,
      REG_LIGHT_TWO     = 4'd2,
      REG_LIGHT_THREE   = 4'd3,
      REG_AMBIENT_GAIN  = 4'd4,
      REG_DIFFUSE_GAIN  = 4'd5,
      REG_SPECULAR_GAIN = 4'd6,
      REG_SHININESS     = 4'd7
   } reg_index_type;

   // Reset values of the gain registers.
   localparam logic [GAIN_W-1:0]  KA_RESET    = 9'd26;
   localparam logic [GAIN_W-1:0]  KD_RESET    = 9'd128;
   localparam logic [GAIN_W-1:0]  KS_RESET    = 9'd128;
   localparam logic [SHINE_W-1:0] SHINE_RESET = 8'd2;

   // Fields of a light register.
   localparam int LDIR_W = 13;
   localparam int LX_LSB = 24;
   localparam int LY_LSB = 37;
   localparam int LZ_LSB = 50;
   localparam int LEN_BIT = 63;

   // Integer square root of the squared normal length (scaled by 2^20).
   localparam int SQRT_BITS = 19;
   localparam int RAD_W     = 38;

   // Normalizing divider: 15 quotient bits, numerator up to 33 bits.
   localparam int DIV_BITS  = 15;
   localparam int DIV_W     = 33;
   localparam int NUM_SHIFT = 24;
   localparam logic [7:0] NZ_RAW = 8'd8;

   // Q1.14 vectors.
   localparam int NRM_W = 16;
   localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;
   localparam logic signed [NRM_W-1:0] L0_X    = -16'sd11408;
   localparam logic signed [NRM_W-1:0] L0_Y    = 16'sd11408;
   localparam logic signed [NRM_W-1:0] L0_Z    = 16'sd2852;

   // One power stage per possible exponent step.
   localparam int POW_STAGES = (1 << SHINE_W) - 1;

   // Channel terms: units of 1/(255 * 2^22).
   localparam int TERM_W = 30;
   localparam logic [TERM_W-1:0] FULL_SCALE = 30'd255 << 22;

   // Queue between the normal unit and the shading pipeline.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [NRM_W-1:0] x;
      logic signed [NRM_W-1:0] y;
      logic signed [NRM_W-1:0] z;
   } normal_type;

   typedef struct packed {
      logic [LIGHT_REGS-1:0][CSR_DATA_W-1:0] light;
      logic [GAIN_W-1:0]                     ka;
      logic [GAIN_W-1:0]                     kd;
      logic [GAIN_W-1:0]                     ks;
      logic [SHINE_W-1:0]                    shine;
   } cfg_type;

endpackage

FILE: rtl/phong_bump_pixel_shader_core.sv
`timescale 1ns / 1ps

// Bump-mapped Phong shader, one pixel per transfer.
// The request channel (req_) carries the four neighbour heights of a pixel;
// the response channel (rsp_) returns its shaded red, green and blue.
// Both use valid/ready; one request gives exactly one response, in order.
// The csr_ channel writes the light, gain and shininess registers by index;
// it is always ready. Write it only while no pixel is in flight; the block
// does not enforce this. Throughput is one pixel per cycle while rsp_ready
// is high. 37 stages form the normal (square root and three dividers, one
// bit per stage), the queue follows, then 262 shading stages, 255 of them
// the power chain that raises N.L to the shininess one multiply per stage.
// A four-entry queue sits between the normal unit and the shading pipeline.
// When rsp_ready is low the shading pipeline holds; the normal unit keeps
// taking requests until the queue fills, then req_ready drops.
// Reset is synchronous: it empties both pipelines and the queue and loads
// the register reset values (lights disabled, so the output is black).

module phong_bump_pixel_shader_core
   import phbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_height_up,
   input  logic [7:0]            req_height_down,
   input  logic [7:0]            req_height_left,
   input  logic [7:0]            req_height_right,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg_ff;
   logic       f_valid, f_ready, q_valid, q_ready;
   normal_type f_normal, q_normal;

   assign csr_ready = 1'b1;

   // Register file; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light <= '0;
         cfg_ff.ka    <= KA_RESET;
         cfg_ff.kd    <= KD_RESET;
         cfg_ff.ks    <= KS_RESET;
         cfg_ff.shine <= SHINE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index) inside
            REG_LIGHT_ZERO, REG_LIGHT_ONE, REG_LIGHT_TWO, REG_LIGHT_THREE: begin
               cfg_ff.light[csr_index[LIGHT_IDX_W-1:0]] <= csr_data;
            end
            REG_AMBIENT_GAIN: begin
               cfg_ff.ka <= csr_data[GAIN_W-1:0];
            end
            REG_DIFFUSE_GAIN: begin
               cfg_ff.kd <= csr_data[GAIN_W-1:0];
            end
            REG_SPECULAR_GAIN: begin
               cfg_ff.ks <= csr_data[GAIN_W-1:0];
            end
            REG_SHININESS: begin
               cfg_ff.shine <= csr_data[SHINE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Normal unit.
   phbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid_i     (req_valid),
      .in_ready_o     (req_ready),
      .height_up_i    (req_height_up),
      .height_down_i  (req_height_down),
      .height_left_i  (req_height_left),
      .height_right_i (req_height_right),
      .out_valid_o    (f_valid),
      .out_ready_i    (f_ready),
      .out_normal_o   (f_normal)
   );

   // Decoupling queue.
   phbs_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid_i (f_valid),
      .push_ready_o (f_ready),
      .push_data_i  (f_normal),
      .pop_valid_o  (q_valid),
      .pop_ready_i  (q_ready),
      .pop_data_o   (q_normal)
   );

   // Shading pipeline.
   phbs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg_i       (cfg_ff),
      .in_valid_i  (q_valid),
      .in_ready_o  (q_ready),
      .in_normal_i (q_normal),
      .out_valid_o (rsp_valid),
      .out_ready_i (rsp_ready),
      .out_red_o   (rsp_red),
      .out_green_o (rsp_green),
      .out_blue_o  (rsp_blue)
   );

endmodule

FILE: rtl/phbs_front.sv
`timescale 1ns / 1ps

module phbs_front
   import phbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid_i,
   output logic       in_ready_o,
   input  logic [7:0] height_up_i,
   input  logic [7:0] height_down_i,
   input  logic [7:0] height_left_i,
   input  logic [7:0] height_right_i,
   output logic       out_valid_o,
   input  logic       out_ready_i,
   output normal_type out_normal_o
);

   logic adv;

   logic                 v0_ff, v1_ff, dv0_ff;
   logic [SQRT_BITS-1:0] sqv_ff;
   logic [DIV_BITS-1:0]  divv_ff;

   logic signed [8:0] nx0_ff, ny0_ff, nx1_ff, ny1_ff;
   logic [16:0]       sq1_ff;
   logic signed [17:0] sqs_in;

   logic [RAD_W-1:0]     rem_ff  [SQRT_BITS];
   logic [SQRT_BITS-1:0] root_ff [SQRT_BITS];
   logic signed [8:0]    nxq_ff  [SQRT_BITS];
   logic signed [8:0]    nyq_ff  [SQRT_BITS];

   logic [2:0][DIV_W-1:0] dnum_ff;
   logic [SQRT_BITS-1:0]  dlen0_ff;
   logic [1:0]            dsgn0_ff;
   logic [2:0][DIV_W-1:0] dnum_in;
   logic [7:0]            ax_in, ay_in;
   logic [SQRT_BITS-1:0]  half_in;

   logic [2:0][DIV_W-1:0]    drem_ff [DIV_BITS];
   logic [2:0][DIV_BITS-1:0] q_ff    [DIV_BITS];
   logic [SQRT_BITS-1:0]     dlen_ff [DIV_BITS];
   logic [1:0]               dsgn_ff [DIV_BITS];

   logic signed [NRM_W-1:0] qx, qy, qz;

   // The whole front moves when its last stage is empty or is taken.
   assign adv         = !divv_ff[DIV_BITS-1] || out_ready_i;
   assign in_ready_o  = adv;
   assign out_valid_o = divv_ff[DIV_BITS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         sqv_ff  <= '0;
         dv0_ff  <= 1'b0;
         divv_ff <= '0;
      end else if (adv) begin
         v0_ff   <= in_valid_i;
         v1_ff   <= v0_ff;
         sqv_ff  <= {sqv_ff[SQRT_BITS-2:0], v1_ff};
         dv0_ff  <= sqv_ff[SQRT_BITS-1];
         divv_ff <= {divv_ff[DIV_BITS-2:0], dv0_ff};
      end
   end

   // Height differences, then the squared length nx^2 + ny^2 + 64.
   assign sqs_in = nx0_ff * nx0_ff + ny0_ff * ny0_ff + 18'sd64;

   always_ff @(posedge clock) begin
      if (adv) begin
         nx0_ff <= $signed({1'b0, height_left_i}) - $signed({1'b0, height_right_i});
         ny0_ff <= $signed({1'b0, height_down_i}) - $signed({1'b0, height_up_i});
         sq1_ff <= sqs_in[16:0];
         nx1_ff <= nx0_ff;
         ny1_ff <= ny0_ff;
      end
   end

   // Square root, one result bit per stage from the top down.
   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
      localparam int B = SQRT_BITS - 1 - j;
      logic [RAD_W-1:0]     rem_prev, trial, rem_in;
      logic [SQRT_BITS-1:0] root_prev, root_in;
      logic signed [8:0]    nx_prev, ny_prev;

      if (j == 0) begin : g_first
         assign rem_prev  = RAD_W'({sq1_ff, 20'b0});
         assign root_prev = '0;
         assign nx_prev   = nx1_ff;
         assign ny_prev   = ny1_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign nx_prev   = nxq_ff[j-1];
         assign ny_prev   = nyq_ff[j-1];
      end

      always_comb begin
         trial = (RAD_W'(root_prev) << (B + 1)) + (RAD_W'(1) << (2 * B));
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (SQRT_BITS'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            nxq_ff[j]  <= nx_prev;
            nyq_ff[j]  <= ny_prev;
         end
      end
   end

   // Divider set-up: magnitudes scaled by 2^24 plus half the length for rounding.
   always_comb begin
      ax_in      = nxq_ff[SQRT_BITS-1][8] ? 8'(-nxq_ff[SQRT_BITS-1]) : nxq_ff[SQRT_BITS-1][7:0];
      ay_in      = nyq_ff[SQRT_BITS-1][8] ? 8'(-nyq_ff[SQRT_BITS-1]) : nyq_ff[SQRT_BITS-1][7:0];
      half_in    = root_ff[SQRT_BITS-1] >> 1;
      dnum_in[0] = (DIV_W'(ax_in) << NUM_SHIFT) + DIV_W'(half_in);
      dnum_in[1] = (DIV_W'(ay_in) << NUM_SHIFT) + DIV_W'(half_in);
      dnum_in[2] = (DIV_W'(NZ_RAW) << NUM_SHIFT) + DIV_W'(half_in);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dnum_ff  <= dnum_in;
         dlen0_ff <= root_ff[SQRT_BITS-1];
         dsgn0_ff <= {nyq_ff[SQRT_BITS-1][8], nxq_ff[SQRT_BITS-1][8]};
      end
   end

   // Restoring division of all three components, one quotient bit per stage.
   for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
      localparam int B = DIV_BITS - 1 - j;
      logic [2:0][DIV_W-1:0]    rem_prev, rem_in;
      logic [2:0][DIV_BITS-1:0] q_prev, q_in;
      logic [SQRT_BITS-1:0]     len_prev;
      logic [1:0]               sgn_prev;
      logic [DIV_W-1:0]         shifted;

      if (j == 0) begin : g_first
         assign rem_prev = dnum_ff;
         assign q_prev   = '0;
         assign len_prev = dlen0_ff;
         assign sgn_prev = dsgn0_ff;
      end else begin : g_next
         assign rem_prev = drem_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign len_prev = dlen_ff[j-1];
         assign sgn_prev = dsgn_ff[j-1];
      end

      always_comb begin
         shifted = DIV_W'(len_prev) << B;
         for (int c = 0; c < 3; c++) begin
            if (rem_prev[c] >= shifted) begin
               rem_in[c] = rem_prev[c] - shifted;
               q_in[c]   = q_prev[c] | (DIV_BITS'(1) << B);
            end else begin
               rem_in[c] = rem_prev[c];
               q_in[c]   = q_prev[c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[j] <= rem_in;
            q_ff[j]    <= q_in;
            dlen_ff[j] <= len_prev;
            dsgn_ff[j] <= sgn_prev;
         end
      end
   end

   // Restore the signs of the lateral components.
   assign qx = $signed({1'b0, q_ff[DIV_BITS-1][0]});
   assign qy = $signed({1'b0, q_ff[DIV_BITS-1][1]});
   assign qz = $signed({1'b0, q_ff[DIV_BITS-1][2]});

   assign out_normal_o.x = dsgn_ff[DIV_BITS-1][0] ? -qx : qx;
   assign out_normal_o.y = dsgn_ff[DIV_BITS-1][1] ? -qy : qy;
   assign out_normal_o.z = qz;

endmodule

FILE: rtl/phbs_queue.sv
`timescale 1ns / 1ps

module phbs_queue
   import phbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid_i,
   output logic       push_ready_o,
   input  normal_type push_data_i,
   output logic       pop_valid_o,
   input  logic       pop_ready_i,
   output normal_type pop_data_o
);

   normal_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              push, pop;

   assign push_ready_o = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid_o  = (cnt_ff != '0);
   assign push         = push_valid_i && push_ready_o;
   assign pop          = pop_valid_o && pop_ready_i;
   assign pop_data_o   = mem_ff[rd_ff];

   // Pointers wrap on their own since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data_i;
      end
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_cnt_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count missed a push");

   a_cnt_down: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("queue count missed a pop");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ff == rd_ff))
      else $error("queue pointers apart while empty");
`endif

endmodule

FILE: rtl/phbs_back.sv
`timescale 1ns / 1ps

module phbs_back
   import phbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg_i,
   input  logic       in_valid_i,
   output logic       in_ready_o,
   input  normal_type in_normal_i,
   output logic       out_valid_o,
   input  logic       out_ready_i,
   output logic [7:0] out_red_o,
   output logic [7:0] out_green_o,
   output logic [7:0] out_blue_o
);

   logic adv;

   // Stage valids.
   logic                  b1v_ff, b2v_ff;
   logic [POW_STAGES-1:0] pv_ff;
   logic [3:0]            sv_ff;
   logic                  rsp_v_ff;

   // Gain times colour, refreshed every cycle from the registers.
   logic [16:0] cka_ff [LIGHT_USED][3];
   logic [16:0] ckd_ff [LIGHT_USED][3];
   logic [16:0] cks_ff [LIGHT_USED][3];

   logic signed [31:0] mx_ff, my_ff, mz_ff;
   normal_type         n1_ff, n2_ff;
   logic signed [33:0] ds_in, dr_in;
   logic signed [NRM_W-1:0] d_in, d2_ff;

   logic signed [NRM_W-1:0] pw_ff [POW_STAGES];
   logic signed [NRM_W-1:0] dd_ff [POW_STAGES];
   normal_type              pn_ff [POW_STAGES];

   logic signed [31:0] spp_ff;
   logic signed [29:0] dp_ff [LIGHT_USED][3];
   logic signed [17:0] spec_ff;
   logic signed [19:0] dif_ff [LIGHT_USED];
   logic signed [37:0] td_ff [LIGHT_USED][3];
   logic signed [35:0] ts_ff [LIGHT_USED][3];
   logic [TERM_W-1:0]  term_ff [LIGHT_USED][3];

   logic [7:0] rgb_ff [3];

   assign adv         = !rsp_v_ff || out_ready_i;
   assign in_ready_o  = adv;
   assign out_valid_o = rsp_v_ff;
   assign out_red_o   = rgb_ff[0];
   assign out_green_o = rgb_ff[1];
   assign out_blue_o  = rgb_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         b1v_ff   <= 1'b0;
         b2v_ff   <= 1'b0;
         pv_ff    <= '0;
         sv_ff    <= '0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         b1v_ff   <= in_valid_i;
         b2v_ff   <= b1v_ff;
         pv_ff    <= {pv_ff[POW_STAGES-2:0], b2v_ff};
         sv_ff    <= {sv_ff[2:0], pv_ff[POW_STAGES-1]};
         rsp_v_ff <= sv_ff[3];
      end
   end

   // Colour-gain products per light and channel.
   always_ff @(posedge clock) begin
      for (int l = 0; l < LIGHT_USED; l++) begin
         for (int c = 0; c < 3; c++) begin
            cka_ff[l][c] <= 17'(cfg_i.light[l][8*c +: 8]) * 17'(cfg_i.ka);
            ckd_ff[l][c] <= 17'(cfg_i.light[l][8*c +: 8]) * 17'(cfg_i.kd);
            cks_ff[l][c] <= 17'(cfg_i.light[l][8*c +: 8]) * 17'(cfg_i.ks);
         end
      end
   end

   // N dot fixed light, rounded and clamped to plus or minus one.
   always_comb begin
      ds_in = mx_ff + my_ff + mz_ff;
      dr_in = (ds_in + 34'sd8192) >>> 14;
      if (dr_in > 34'sd16384) begin
         d_in = ONE_Q14;
      end else if (dr_in < -34'sd16384) begin
         d_in = -ONE_Q14;
      end else begin
         d_in = dr_in[NRM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= in_normal_i.x * L0_X;
         my_ff <= in_normal_i.y * L0_Y;
         mz_ff <= in_normal_i.z * L0_Z;
         n1_ff <= in_normal_i;
         d2_ff <= d_in;
         n2_ff <= n1_ff;
      end
   end

   // Power chain: stage k multiplies once more while k is below the exponent.
   for (genvar k = 0; k < POW_STAGES; k++) begin : g_pow
      localparam logic [SHINE_W-1:0] K = SHINE_W'(k);
      logic signed [NRM_W-1:0] p_prev, d_prev, p_in;
      logic signed [32:0]      prod;
      normal_type              n_prev;

      if (k == 0) begin : g_first
         assign p_prev = ONE_Q14;
         assign d_prev = d2_ff;
         assign n_prev = n2_ff;
      end else begin : g_next
         assign p_prev = pw_ff[k-1];
         assign d_prev = dd_ff[k-1];
         assign n_prev = pn_ff[k-1];
      end

      always_comb begin
         prod = ((p_prev * d_prev) + 33'sd8192) >>> 14;
         p_in = (K < cfg_i.shine) ? prod[NRM_W-1:0] : p_prev;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pw_ff[k] <= p_in;
            dd_ff[k] <= d_prev;
            pn_ff[k] <= n_prev;
         end
      end
   end

   // Specular product and per-light dot products.
   always_ff @(posedge clock) begin
      if (adv) begin
         spp_ff <= pw_ff[POW_STAGES-1] * pn_ff[POW_STAGES-1].z;
         for (int l = 0; l < LIGHT_USED; l++) begin
            dp_ff[l][0] <= pn_ff[POW_STAGES-1].x
                           * $signed(cfg_i.light[l][LX_LSB +: LDIR_W]);
            dp_ff[l][1] <= pn_ff[POW_STAGES-1].y
                           * $signed(cfg_i.light[l][LY_LSB +: LDIR_W]);
            dp_ff[l][2] <= pn_ff[POW_STAGES-1].z
                           * $signed(cfg_i.light[l][LZ_LSB +: LDIR_W]);
         end
      end
   end

   // Round the specular factor to Q1.14 and the diffuse dots from Q1.25.
   always_ff @(posedge clock) begin
      logic signed [33:0] s_w;
      logic signed [31:0] d_w;
      if (adv) begin
         s_w     = spp_ff;
         s_w     = ((s_w <<< 1) + 34'sd8192) >>> 14;
         s_w     = s_w - 34'sd2852;
         spec_ff <= s_w[17:0];
         for (int l = 0; l < LIGHT_USED; l++) begin
            d_w        = dp_ff[l][0];
            d_w        = d_w + dp_ff[l][1] + dp_ff[l][2] + 32'sd1024;
            d_w        = d_w >>> 11;
            dif_ff[l] <= d_w[19:0];
         end
      end
   end

   // Diffuse and specular channel terms.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LIGHT_USED; l++) begin
            for (int c = 0; c < 3; c++) begin
               td_ff[l][c] <= $signed({1'b0, ckd_ff[l][c]}) * dif_ff[l];
               ts_ff[l][c] <= $signed({1'b0, cks_ff[l][c]}) * spec_ff;
            end
         end
      end
   end

   // Per-light sum, negatives floored, capped at full scale, masked by enable.
   always_ff @(posedge clock) begin
      logic signed [39:0] t_w;
      if (adv) begin
         for (int l = 0; l < LIGHT_USED; l++) begin
            for (int c = 0; c < 3; c++) begin
               t_w = $signed({9'b0, cka_ff[l][c], 14'b0});
               if (!td_ff[l][c][37]) begin
                  t_w = t_w + td_ff[l][c];
               end
               if (!ts_ff[l][c][35]) begin
                  t_w = t_w + ts_ff[l][c];
               end
               if (!cfg_i.light[l][LEN_BIT]) begin
                  term_ff[l][c] <= '0;
               end else if (t_w > $signed({10'b0, FULL_SCALE})) begin
                  term_ff[l][c] <= FULL_SCALE;
               end else begin
                  term_ff[l][c] <= t_w[TERM_W-1:0];
               end
            end
         end
      end
   end

   // Accumulate over lights, clamp and round to 8 bits into the result register.
   always_ff @(posedge clock) begin
      logic [31:0] acc_w;
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            acc_w = '0;
            for (int l = 0; l < LIGHT_USED; l++) begin
               acc_w = acc_w + 32'(term_ff[l][c]);
            end
            if (acc_w > 32'(FULL_SCALE)) begin
               acc_w = 32'(FULL_SCALE);
            end
            acc_w     = (acc_w + 32'd2097152) >> 22;
            rgb_ff[c] <= acc_w[7:0];
         end
      end
   end

endmodule
